// File: rtl/core/gpc_pkg.sv
// Shared types and constants for the grid path counter.
// Used by gpc_ctrl, gpc_datapath and grid_path_counter_top; no dependencies.
`default_nettype none

package gpc_pkg;

    // Width of the rows / cols request fields
    localparam int DIM_BITS = 7;
    // Width of the path_count result field
    localparam int COUNT_OUT_BITS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_FINISH
    } gpc_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic commit;
        logic publish;
    } gpc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic more;
        logic div_last;
    } gpc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/gpc_datapath.sv
// Datapath of the grid path counter: operand registers, multiplier,
// restoring divider and result register. Depends on gpc_pkg.
`default_nettype none

module gpc_datapath
    import gpc_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gpc_cmd_t                  cmd,
    output gpc_status_t                    status,
    input  wire logic [DIM_BITS-1:0]       rows,
    input  wire logic [DIM_BITS-1:0]       cols,
    output logic [COUNT_OUT_BITS-1:0]      path_count,
    output logic                           overflow
);

    localparam int PW    = COUNT_BITS + DIM_BITS;
    localparam int CNT_W = $clog2(PW);
    localparam int WIDE  = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;
    localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);

    logic [DIM_BITS-1:0]       rows_c;
    logic [DIM_BITS-1:0]       cols_c;
    logic [DIM_BITS-1:0]       dim_lo;
    logic [DIM_BITS-1:0]       dim_hi;
    logic [DIM_BITS-1:0]       k_val;
    logic [DIM_BITS:0]         rem_shift;
    logic                      rem_fit;
    logic                      quo_over;
    logic [WIDE-1:0]           acc_wide;

    logic [DIM_BITS-1:0]       base_reg;
    logic [DIM_BITS-1:0]       r_reg;
    logic [DIM_BITS-1:0]       i_reg;
    logic                      zero_reg;
    logic                      ovf_reg;
    logic [COUNT_BITS-1:0]     acc_reg;
    logic [PW-1:0]             quo_reg;
    logic [DIM_BITS-1:0]       rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [COUNT_OUT_BITS-1:0] path_count_reg;
    logic                      overflow_reg;

    // Clamp dimensions and pick the short and long side
    always_comb
    begin
        rows_c = (rows > DIM_MAX) ? DIM_MAX : rows;
        cols_c = (cols > DIM_MAX) ? DIM_MAX : cols;
        dim_lo = (rows_c < cols_c) ? rows_c : cols_c;
        dim_hi = (rows_c < cols_c) ? cols_c : rows_c;
    end

    // Numerator factor of the current step: (long side - 1) + i
    assign k_val = base_reg + i_reg;

    // One restoring division step on the product
    assign rem_shift = {rem_reg, quo_reg[PW-1]};
    assign rem_fit   = (rem_shift >= {1'b0, i_reg});
    assign quo_over  = |quo_reg[PW-1:COUNT_BITS];
    assign acc_wide  = WIDE'(acc_reg);

    assign status.more     = !zero_reg && !ovf_reg && (i_reg <= r_reg);
    assign status.div_last = (cnt_reg == CNT_W'(PW - 1));

    // Operand, accumulator and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= dim_hi - DIM_BITS'(1);
            r_reg    <= dim_lo - DIM_BITS'(1);
            i_reg    <= DIM_BITS'(1);
            zero_reg <= (dim_lo == '0);
            ovf_reg  <= 1'b0;
            acc_reg  <= (dim_lo == '0) ? '0 : COUNT_BITS'(1);
        end
        if (cmd.mul)
        begin
            quo_reg <= PW'(acc_reg) * PW'(k_val);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div)
        begin
            quo_reg <= {quo_reg[PW-2:0], rem_fit};
            rem_reg <= rem_fit ? DIM_BITS'(rem_shift - {1'b0, i_reg})
                               : rem_shift[DIM_BITS-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        // Accept the quotient or saturate and stop
        if (cmd.commit)
        begin
            if (quo_over)
            begin
                ovf_reg <= 1'b1;
                acc_reg <= '1;
            end
            else
            begin
                acc_reg <= quo_reg[COUNT_BITS-1:0];
                i_reg   <= i_reg + DIM_BITS'(1);
            end
        end
    end

    // Result register, loaded when the controller hands the result out
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            path_count_reg <= acc_wide[COUNT_OUT_BITS-1:0];
            overflow_reg   <= ovf_reg;
        end
    end

    assign path_count = path_count_reg;
    assign overflow   = overflow_reg;

    // Remainder of an exact division step stays below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |=> (rem_reg < i_reg))
        else $error("divider remainder reached the divisor");

    // A step that fits advances the step index by one
    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !quo_over) |=> (i_reg == $past(i_reg) + DIM_BITS'(1)))
        else $error("step index did not advance");

    // Saturation ends the iteration
    a_ovf_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && quo_over) |=> !status.more)
        else $error("iteration continued after saturation");

endmodule

`default_nettype wire

// File: rtl/core/gpc_ctrl.sv
// Controller of the grid path counter: sequences load, multiply, divide,
// commit and hand-off; owns the request handshakes. Depends on gpc_pkg.
`default_nettype none

module gpc_ctrl
    import gpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output gpc_cmd_t         cmd,
    input  wire gpc_status_t status
);

    gpc_state_t state_reg;
    gpc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Hold state and result-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.more ? ST_MUL : ST_FINISH;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Raise valid on hand-off, drop it when the result request is taken
    always_comb
    begin
        priority if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// File: rtl/core/grid_path_counter_top.sv
// Grid path counter: one request (rows, cols) gives one result, the number of
// monotone right/down paths across the grid, C(rows+cols-2, min(rows,cols)-1),
// computed exactly by acc <- acc * k / i for i = 1 .. min-1. Each step runs a
// multiply, a division in a bit-serial restoring divider, then commit and check.
// Dimensions above MAX_DIM are clamped; a zero dimension gives 0. A count above
// 2^COUNT_BITS-1 saturates there, raises overflow and ends the iteration early.
// A new request is accepted while the previous result still waits in the output
// register.
// Depends on gpc_pkg, gpc_ctrl and gpc_datapath.
`default_nettype none

module grid_path_counter_top
    import gpc_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [DIM_BITS-1:0]       rows,
    input  wire logic [DIM_BITS-1:0]       cols,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COUNT_OUT_BITS-1:0]      path_count,
    output logic                           overflow
);

    gpc_cmd_t    cmd;
    gpc_status_t status;

    gpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    gpc_datapath #(
        .MAX_DIM    (MAX_DIM),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .rows       (rows),
        .cols       (cols),
        .path_count (path_count),
        .overflow   (overflow)
    );

endmodule

`default_nettype wire

// File: test/grid_path_counter_checker.sv
`timescale 1ns / 1ps
// Checker for grid_path_counter_top: watches both channels, predicts each path count
// from the request and compares it with the result. Depends on gpc_pkg only.

module grid_path_counter_checker
    import gpc_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [DIM_BITS-1:0]       rows,
    input  logic [DIM_BITS-1:0]       cols,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [COUNT_OUT_BITS-1:0] path_count,
    input  logic                      overflow,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        saturated
);

    typedef struct packed {
        logic [COUNT_OUT_BITS-1:0] count;
        logic                      ovf;
    } path_result_t;

    // Counts still owed by the block, oldest first
    path_result_t owed_counts[$];

    // Exact C(rows+cols-2, min-1) by the gcd-reduced running product, saturated
    function automatic path_result_t lattice_path_count(
        input logic [DIM_BITS-1:0] r_in,
        input logic [DIM_BITS-1:0] c_in
    );
        longint unsigned n_rows, n_cols, total, steps, i;
        longint unsigned acc, k, g, a, x, t, f, lim;
        logic            sat;
        path_result_t    res;
        n_rows = (r_in > MAX_DIM) ? MAX_DIM : r_in;
        n_cols = (c_in > MAX_DIM) ? MAX_DIM : c_in;
        lim    = {64{1'b1}} >> (64 - COUNT_BITS);
        acc    = 1;
        sat    = 1'b0;
        // A zero dimension has no paths at all
        if (n_rows == 0 || n_cols == 0) begin
            res.count = '0;
            res.ovf   = 1'b0;
            return res;
        end
        total = n_rows + n_cols - 2;
        steps = ((n_rows < n_cols) ? n_rows : n_cols) - 1;
        for (i = 1; i <= steps && !sat; i++) begin
            k = total - steps + i;
            // Reduce acc and i by their gcd so the product stays in range
            a = acc;
            x = i;
            while (x != 0) begin
                t = a % x;
                a = x;
                x = t;
            end
            g = a;
            a = acc / g;
            f = k / (i / g);
            if (a != 0 && f > lim / a)
                sat = 1'b1;
            else
                acc = a * f;
        end
        if (sat)
            acc = lim;
        res.count = acc[COUNT_OUT_BITS-1:0];
        res.ovf   = sat;
        return res;
    endfunction

    initial begin
        errors    = 0;
        pending   = 0;
        checked   = 0;
        saturated = 0;
    end

    // Retire a result first, then record a new request, so same-edge traffic stays ordered
    always @(posedge clk) begin : watch_channels
        path_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (owed_counts.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: result with nothing owed: count %0d overflow %0b",
                             $time, path_count, overflow);
                end else begin
                    want = owed_counts.pop_front();
                    checked <= checked + 1;
                    if (want.ovf)
                        saturated <= saturated + 1;
                    if (path_count !== want.count || overflow !== want.ovf) begin
                        errors <= errors + 1;
                        $display("%0t: mismatch: expected count %0d overflow %0b, got %0d %0b",
                                 $time, want.count, want.ovf, path_count, overflow);
                    end
                end
            end
            if (in_valid && in_ready)
                owed_counts.push_back(lattice_path_count(rows, cols));
        end
        pending <= owed_counts.size();
    end

endmodule

// File: test/grid_path_counter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for grid_path_counter_top: drives grid-size requests and result
// back-pressure, gives the verdict. Depends on gpc_pkg and grid_path_counter_checker.

module grid_path_counter_top_tb
    import gpc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 3000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [DIM_BITS-1:0]       rows;
    logic [DIM_BITS-1:0]       cols;
    logic                      out_valid;
    logic                      out_ready;
    logic [COUNT_OUT_BITS-1:0] path_count;
    logic                      overflow;

    int errors;
    int pending;
    int checked;
    int saturated;
    int src_idle_pct;
    int dst_idle_pct;
    int sent;
    int cycles;

    grid_path_counter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rows       (rows),
        .cols       (cols),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_count (path_count),
        .overflow   (overflow)
    );

    grid_path_counter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rows       (rows),
        .cols       (cols),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_count (path_count),
        .overflow   (overflow),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .saturated  (saturated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= dst_idle_pct);

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
            $display("FAIL grid_path_counter_top");
            $finish;
        end
    end

    // Hold one request on the channel until it is taken, idling before it at random
    task automatic send_request(input logic [DIM_BITS-1:0] r, input logic [DIM_BITS-1:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rows     <= r;
        cols     <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Pick a grid size: mostly small, some near the overflow edge, some anything at all
    task automatic send_random_request();
        logic [DIM_BITS-1:0] r;
        logic [DIM_BITS-1:0] c;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r = DIM_BITS'($urandom_range(1, 12));
            c = DIM_BITS'($urandom_range(1, 12));
        end else if (pick < 65) begin
            r = DIM_BITS'($urandom_range(1, 6));
            c = DIM_BITS'($urandom_range(0, 127));
            if ($urandom_range(0, 1) != 0) begin
                r = c;
                c = DIM_BITS'($urandom_range(1, 6));
            end
        end else if (pick < 80) begin
            r = DIM_BITS'($urandom_range(14, 22));
            c = DIM_BITS'($urandom_range(14, 22));
        end else if (pick < 95) begin
            r = DIM_BITS'($urandom_range(0, 127));
            c = DIM_BITS'($urandom_range(0, 127));
        end else begin
            r = ($urandom_range(0, 1) != 0) ? '0 : DIM_BITS'($urandom_range(0, 127));
            c = (r == '0) ? DIM_BITS'($urandom_range(0, 127)) : '0;
        end
        send_request(r, c);
    endtask

    initial begin
        in_valid     = 1'b0;
        rows         = '0;
        cols         = '0;
        out_ready    = 1'b0;
        rst_n        = 1'b0;
        cycles       = 0;
        sent         = 0;
        src_idle_pct = 12;
        dst_idle_pct = 45;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-by-one, zero sizes, clamping, overflow edges, all-ones fields
        send_request(7'd1, 7'd1);
        send_request(7'd0, 7'd0);
        send_request(7'd0, 7'd5);
        send_request(7'd9, 7'd0);
        send_request(7'd127, 7'd0);
        send_request(7'd1, 7'd64);
        send_request(7'd64, 7'd1);
        send_request(7'd2, 7'd2);
        send_request(7'd2, 7'd64);
        send_request(7'd3, 7'd3);
        send_request(7'd17, 7'd17);
        send_request(7'd18, 7'd18);
        send_request(7'd19, 7'd19);
        send_request(7'd18, 7'd19);
        send_request(7'd64, 7'd8);
        send_request(7'd9, 7'd64);
        send_request(7'd64, 7'd64);
        send_request(7'd65, 7'd3);
        send_request(7'd3, 7'd100);
        send_request(7'd127, 7'd127);
        send_request(7'd127, 7'd1);
        send_request(7'd64, 7'd2);
        send_request(7'd33, 7'd4);

        // Random, under three idling regimes
        repeat (70) send_random_request();
        src_idle_pct = 45;
        dst_idle_pct = 12;
        repeat (70) send_random_request();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        repeat (70) send_random_request();
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d grid sizes, checked %0d path counts (%0d saturated), %0d errors",
                 sent, checked, saturated, errors);
        if (errors == 0 && pending == 0)
            $display("PASS grid_path_counter_top");
        else
            $display("FAIL grid_path_counter_top");
        $finish;
    end

endmodule
